/* rtl/clns_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package clns_pkg;

    // request kinds
    localparam logic [2:0] REQ_CMD    = 3'd0;
    localparam logic [2:0] REQ_DATA   = 3'd1;
    localparam logic [2:0] REQ_CURSOR = 3'd2;
    localparam logic [2:0] REQ_INIT   = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_PULSE  = 2'd0;
    localparam logic [1:0] REG_GAP    = 2'd1;
    localparam logic [1:0] REG_SETTLE = 2'd2;

    // program entry points
    localparam logic [3:0] UC_CMD    = 4'd0;
    localparam logic [3:0] UC_DATA   = 4'd1;
    localparam logic [3:0] UC_CURSOR = 4'd2;
    localparam logic [3:0] UC_INIT   = 4'd3;
    localparam logic [3:0] UC_CLEAR  = 4'd8;

    localparam logic [7:0] ROW0_BASE  = 8'h80;
    localparam logic [7:0] ROW1_BASE  = 8'hC0;

    // one control word per byte step; four pin events per step
    typedef struct packed {
        logic       use_arg;     // send the captured request byte
        logic [7:0] const_byte;  // else send this constant
        logic       rs;          // register select level
        logic       fin;         // last byte of the run, return to idle
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [3:0] pc);
        ucode_t w;
        w = '{use_arg: 1'b0, const_byte: 8'h00, rs: 1'b0, fin: 1'b1};
        unique case (pc)
            4'd0:    w = '{use_arg: 1'b1, const_byte: 8'h00, rs: 1'b0, fin: 1'b1};
            4'd1:    w = '{use_arg: 1'b1, const_byte: 8'h00, rs: 1'b1, fin: 1'b1};
            4'd2:    w = '{use_arg: 1'b1, const_byte: 8'h00, rs: 1'b0, fin: 1'b1};
            4'd3:    w = '{use_arg: 1'b0, const_byte: 8'h02, rs: 1'b0, fin: 1'b0};
            4'd4:    w = '{use_arg: 1'b0, const_byte: 8'h28, rs: 1'b0, fin: 1'b0};
            4'd5:    w = '{use_arg: 1'b0, const_byte: 8'h0C, rs: 1'b0, fin: 1'b0};
            4'd6:    w = '{use_arg: 1'b0, const_byte: 8'h06, rs: 1'b0, fin: 1'b0};
            4'd7:    w = '{use_arg: 1'b0, const_byte: 8'h01, rs: 1'b0, fin: 1'b1};
            4'd8:    w = '{use_arg: 1'b0, const_byte: 8'h01, rs: 1'b0, fin: 1'b0};
            4'd9:    w = '{use_arg: 1'b0, const_byte: 8'h80, rs: 1'b0, fin: 1'b1};
            default: w = '{use_arg: 1'b0, const_byte: 8'h00, rs: 1'b0, fin: 1'b1};
        endcase
        return w;
    endfunction

    function automatic logic [3:0] ucode_entry(input logic [2:0] kind);
        logic [3:0] e;
        e = UC_CMD;
        unique case (kind)
            REQ_CMD:    e = UC_CMD;
            REQ_DATA:   e = UC_DATA;
            REQ_CURSOR: e = UC_CURSOR;
            REQ_INIT:   e = UC_INIT;
            REQ_CLEAR:  e = UC_CLEAR;
            default:    e = UC_CMD;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

/* rtl/char_lcd_nibble_sequencer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel  | dir | transaction                 | payload
// s_axis   | in  | one display request         | s_tdata: req_type, byte_value, row, col
// m_axis   | out | one pin event               | m_tdata: nibble, en, hold_us; m_tuser: rs;
//          |     |                             | m_tlast: final event of the run
// apb      | in  | register write / read       | pulse (0x0), gap (0x4), settle (0x8)
//
// a request is taken while idle, then the program emits one event per cycle
// while m_tready is high: 4 events per byte, so 4, 8 or 20 events per request
// the rate is set by the single event output register fed by the microcode step
// unused request kinds are taken and dropped with no events
// aresetn is synchronous: it returns the sequencer to idle, drops m_tvalid and
// loads the reset register values; a stall on m_tready freezes the step counter

module char_lcd_nibble_sequencer_unit
    import clns_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // req_type[2:0], byte_value[10:3], row[12:11], col[17:13]

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // nibble[3:0], en[4], hold_us[20:5]
    output logic             m_tuser,   // rs[0]
    output logic             m_tlast,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // input fields
    logic [2:0] req_type;
    logic [7:0] byte_value;
    logic [1:0] row;
    logic [4:0] col;

    assign req_type   = s_tdata[2:0];
    assign byte_value = s_tdata[10:3];
    assign row        = s_tdata[12:11];
    assign col        = s_tdata[17:13];

    // configuration registers
    logic [7:0]  pulse_reg;
    logic [15:0] gap_reg;
    logic [15:0] settle_reg;

    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_reg  <= 8'd2;
            gap_reg    <= 16'd200;
            settle_reg <= 16'd2;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_PULSE:  pulse_reg  <= pwdata[7:0];
                REG_GAP:    gap_reg    <= pwdata[15:0];
                REG_SETTLE: settle_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_PULSE:  prdata = {24'd0, pulse_reg};
            REG_GAP:    prdata = {16'd0, gap_reg};
            REG_SETTLE: prdata = {16'd0, settle_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // sequencer state
    logic       state_reg, state_next;
    logic [3:0] pc_reg, pc_next;
    logic [1:0] phase_reg, phase_next;
    logic [7:0] arg_reg, arg_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [23:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;
    logic        m_tlast_reg, m_tlast_next;

    logic       s_fire;
    logic       kind_ok;
    logic       slot_free;
    logic [7:0] row_base;
    logic [7:0] cursor_addr;
    ucode_t     uw;
    logic [7:0] cur_byte;
    logic [3:0] ev_nibble;
    logic       ev_en;
    logic [15:0] ev_hold;
    logic       ev_last;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign kind_ok   = (req_type == REQ_CMD) || (req_type == REQ_DATA) ||
                       (req_type == REQ_CURSOR) || (req_type == REQ_INIT) ||
                       (req_type == REQ_CLEAR);
    assign slot_free = !m_tvalid_reg || m_tready;

    // cursor address: row base plus column when the column is on screen
    always_comb begin
        case (row)
            2'd0:    row_base = ROW0_BASE;
            2'd1:    row_base = ROW1_BASE;
            default: row_base = 8'h00;
        endcase
    end
    assign cursor_addr = row_base + (col[4] ? 8'd0 : {4'd0, col[3:0]});

    // datapath driven by the current control word and event phase
    assign uw        = ucode_rom(pc_reg);
    assign cur_byte  = uw.use_arg ? arg_reg : uw.const_byte;
    assign ev_nibble = phase_reg[1] ? cur_byte[3:0] : cur_byte[7:4];
    assign ev_en     = !phase_reg[0];
    assign ev_last   = uw.fin && (phase_reg == 2'd3);

    always_comb begin
        case (phase_reg)
            2'd1:    ev_hold = gap_reg;
            2'd3:    ev_hold = settle_reg;
            default: ev_hold = {8'd0, pulse_reg};
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        pc_next       = pc_reg;
        phase_next    = phase_reg;
        arg_next      = arg_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && kind_ok) begin
                    state_next = ST_RUN;
                    pc_next    = ucode_entry(req_type);
                    phase_next = 2'd0;
                    arg_next   = (req_type == REQ_CURSOR) ? cursor_addr : byte_value;
                end
            end
            ST_RUN: begin
                if (slot_free) begin
                    // emit one event and step the program
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'd0, ev_hold, ev_en, ev_nibble};
                    m_tuser_next  = uw.rs;
                    m_tlast_next  = ev_last;
                    phase_next    = phase_reg + 2'd1;
                    if (phase_reg == 2'd3) begin
                        if (uw.fin) begin
                            state_next = ST_IDLE;
                        end else begin
                            pc_next = pc_reg + 4'd1;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pc_reg       <= UC_CMD;
            phase_reg    <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pc_reg       <= pc_next;
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        arg_reg     <= arg_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

/* rtl/clns_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module clns_checker
    import clns_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [23:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    // stalled event holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled event changed");

    // a run always ends on an enable-low event
    a_last_en_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tdata[4])
        else $error("run ended with enable high");

    // a known request blocks new input while its run is emitted
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready &&
        (s_tdata[2:0] == REQ_CMD || s_tdata[2:0] == REQ_DATA ||
         s_tdata[2:0] == REQ_CURSOR || s_tdata[2:0] == REQ_INIT ||
         s_tdata[2:0] == REQ_CLEAR) |=> !s_tready)
        else $error("input taken during a run");

    // reset clears the output channel
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output valid after reset");

endmodule

bind char_lcd_nibble_sequencer_unit clns_checker u_clns_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
